>>> design/gmte_pkg.sv
// Shared types and constants for the two-byte text extents block.
// Holds op and register codes, metric and lookup structs; no dependencies.
`default_nettype none

package gmte_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IDX_W       = 17;
	localparam int NUM_REGS    = 6;
	localparam int REG_AW      = 3;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_COMMON = 2'd1,
		OP_CHAR   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic [REG_AW-1:0] {
		REG_MIN_COL       = 3'd0,
		REG_MAX_COL       = 3'd1,
		REG_MIN_ROW       = 3'd2,
		REG_MAX_ROW       = 3'd3,
		REG_DEFAULT_CODE  = 3'd4,
		REG_TABLE_PRESENT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] lb;
		logic signed [15:0] rb;
		logic signed [15:0] w;
		logic signed [15:0] asc;
		logic signed [15:0] desc;
	} metrics_t;

	typedef struct packed {
		logic [7:0]  min_col;
		logic [7:0]  max_col;
		logic [7:0]  min_row;
		logic [7:0]  max_row;
		logic [15:0] default_code;
		logic        table_present;
	} cfg_t;

	typedef struct packed {
		logic              ok;
		logic [TBL_AW-1:0] idx;
	} lookup_t;

	typedef struct packed {
		logic     valid;
		op_t      op;
		logic     found;
		metrics_t m;
	} acc_item_t;

endpackage

`default_nettype wire

>>> design/gmte_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No package dependency.
`default_nettype none

module gmte_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 80,
	parameter int AW    = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> design/gmte_index.sv
// Range check and table index for one (row, column) code.
// Depends on gmte_pkg for the configuration and lookup structs.
`default_nettype none

module gmte_index (
	input  wire logic [7:0]       row,
	input  wire logic [7:0]       col,
	input  wire logic             allow_1d,
	input  wire gmte_pkg::cfg_t   cfg,
	output gmte_pkg::lookup_t     result
);

	import gmte_pkg::*;

	logic             one_d;
	logic             col_in;
	logic             row_in;
	logic             in_range;
	logic [7:0]       col_off;
	logic [7:0]       row_off;
	logic [8:0]       ncol;
	logic [IDX_W-1:0] idx_full;

	always_comb begin
		one_d    = allow_1d && (cfg.max_row == 8'd0) && (row == 8'd0);
		col_in   = (col >= cfg.min_col) && (col <= cfg.max_col);
		row_in   = (row >= cfg.min_row) && (row <= cfg.max_row);
		in_range = one_d ? col_in : (row_in && col_in);
		col_off  = col - cfg.min_col;
		row_off  = one_d ? 8'd0 : (row - cfg.min_row);
		ncol     = {1'b0, cfg.max_col} - {1'b0, cfg.min_col} + 9'd1;
		idx_full = IDX_W'(row_off * ncol) + IDX_W'(col_off);
		// common metrics skip the table bound
		result.ok  = in_range &&
		             (!cfg.table_present || (idx_full < IDX_W'(TABLE_DEPTH)));
		result.idx = idx_full[TBL_AW-1:0];
	end

endmodule

`default_nettype wire

>>> design/gmte_accum.sv
// Extents accumulator and result register for the text extents block.
// Depends on gmte_pkg for the item struct and op codes.
`default_nettype none

module gmte_accum (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gmte_pkg::acc_item_t item,
	output logic                     blocked,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       total_width,
	output logic signed [15:0]       total_ascent,
	output logic signed [15:0]       total_descent,
	output logic signed [31:0]       total_lbearing,
	output logic signed [31:0]       total_rbearing,
	output logic        [15:0]       chars_found
);

	import gmte_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat32 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic signed [31:0] acc_w_q;
	logic signed [15:0] acc_asc_q;
	logic signed [15:0] acc_desc_q;
	logic signed [31:0] acc_lb_q;
	logic signed [31:0] acc_rb_q;
	logic        [15:0] count_q;

	logic               take;
	logic               do_char;
	logic               do_end;
	logic signed [32:0] l_sum;
	logic signed [32:0] r_sum;
	logic signed [32:0] w_sum;
	logic               empty;

	always_comb begin
		blocked = item.valid && (item.op == OP_END) && out_valid && out_stall;
		take    = item.valid && !blocked;
		do_char = take && (item.op == OP_CHAR) && item.found;
		do_end  = take && (item.op == OP_END);
		l_sum   = 33'(acc_w_q) + 33'(item.m.lb);
		r_sum   = 33'(acc_w_q) + 33'(item.m.rb);
		w_sum   = 33'(acc_w_q) + 33'(item.m.w);
		empty   = (count_q == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_w_q    <= '0;
			acc_asc_q  <= '0;
			acc_desc_q <= '0;
			acc_lb_q   <= '0;
			acc_rb_q   <= '0;
			count_q    <= '0;
		end else if (do_end) begin
			acc_w_q    <= '0;
			acc_asc_q  <= '0;
			acc_desc_q <= '0;
			acc_lb_q   <= '0;
			acc_rb_q   <= '0;
			count_q    <= '0;
		end else if (do_char) begin
			if (empty) begin
				acc_w_q    <= 32'(item.m.w);
				acc_asc_q  <= item.m.asc;
				acc_desc_q <= item.m.desc;
				acc_lb_q   <= 32'(item.m.lb);
				acc_rb_q   <= 32'(item.m.rb);
			end else begin
				if (item.m.asc > acc_asc_q) begin
					acc_asc_q <= item.m.asc;
				end
				if (item.m.desc > acc_desc_q) begin
					acc_desc_q <= item.m.desc;
				end
				if (l_sum < 33'(acc_lb_q)) begin
					acc_lb_q <= sat32(l_sum);
				end
				if (r_sum > 33'(acc_rb_q)) begin
					acc_rb_q <= sat32(r_sum);
				end
				acc_w_q <= sat32(w_sum);
			end
			if (count_q != 16'hffff) begin
				count_q <= count_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (do_end) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// accumulators already read as zero when nothing was found
	always_ff @(posedge clk) begin
		if (do_end) begin
			total_width    <= acc_w_q;
			total_ascent   <= acc_asc_q;
			total_descent  <= acc_desc_q;
			total_lbearing <= acc_lb_q;
			total_rbearing <= acc_rb_q;
			chars_found    <= count_q;
		end
	end

endmodule

`default_nettype wire

>>> design/glyph_metrics_text_extents_top.sv
// Top level of the two-byte text extents block: pipeline, metrics RAM, config.
// Depends on gmte_pkg, gmte_ram, gmte_index and gmte_accum.
`default_nettype none

// Takes one transaction per clock: table loads, common metric loads, characters
// and end-of-string ops all enter back to back. Every op goes through three
// stages: the accept edge computes both the character's table index and the
// default character's index and reads them together through the two read ports
// of the metrics RAM; stage one checks for a missing entry and selects primary,
// default or common metrics; stage two folds them into the accumulators. An end
// op leaves its totals in the result register as it leaves stage two.
// The only source of input stall is the result register: while it holds an
// unread result, an end op waits in stage two and the stages behind it fill up;
// loads and characters keep flowing until then. The table has no reset; read
// only entries that have been loaded. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be made while the block is idle.
module glyph_metrics_text_extents_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [gmte_pkg::REG_AW-1:0]  cfg_index,
	input  wire logic [15:0]                  cfg_data,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   op,
	input  wire logic [7:0]                   char_row,
	input  wire logic [7:0]                   char_col,
	input  wire logic [11:0]                  entry_index,
	input  wire logic signed [15:0]           metric_lbearing,
	input  wire logic signed [15:0]           metric_rbearing,
	input  wire logic signed [15:0]           metric_width,
	input  wire logic signed [15:0]           metric_ascent,
	input  wire logic signed [15:0]           metric_descent,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                total_width,
	output logic signed [15:0]                total_ascent,
	output logic signed [15:0]                total_descent,
	output logic signed [31:0]                total_lbearing,
	output logic signed [31:0]                total_rbearing,
	output logic        [15:0]                chars_found
);

	import gmte_pkg::*;

	localparam int MW = $bits(metrics_t);

	// configuration registers
	cfg_t     cfg_q;
	metrics_t common_q;

	// accept stage
	op_t         in_op;
	logic        in_acc;
	metrics_t    in_m;
	lookup_t     pri_lk;
	lookup_t     def_lk;
	logic [16:0] ent_ext;
	logic        ram_we;
	logic [MW-1:0] rd_a;
	logic [MW-1:0] rd_b;

	// stage one
	logic     valid_s1;
	op_t      op_s1;
	logic     pri_ok_s1;
	logic     def_ok_s1;
	metrics_t pri_m;
	metrics_t def_m;
	logic     pri_found;
	logic     def_found;
	logic     adv_s1;

	// stage two
	logic      valid_s2;
	op_t       op_s2;
	logic      found_s2;
	metrics_t  m_s2;
	acc_item_t item_s2;
	logic      blocked;
	logic      s2_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_col       <= 8'd0;
			cfg_q.max_col       <= 8'hff;
			cfg_q.min_row       <= 8'd0;
			cfg_q.max_row       <= 8'd0;
			cfg_q.default_code  <= 16'd0;
			cfg_q.table_present <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_COL:       cfg_q.min_col       <= cfg_data[7:0];
				REG_MAX_COL:       cfg_q.max_col       <= cfg_data[7:0];
				REG_MIN_ROW:       cfg_q.min_row       <= cfg_data[7:0];
				REG_MAX_ROW:       cfg_q.max_row       <= cfg_data[7:0];
				REG_DEFAULT_CODE:  cfg_q.default_code  <= cfg_data;
				REG_TABLE_PRESENT: cfg_q.table_present <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Accept stage: handshake, index computation, RAM access.
	always_comb begin
		in_op     = op_t'(op);
		s2_free   = !valid_s2 || !blocked;
		in_stall  = valid_s1 && !s2_free;
		in_acc    = in_valid && !in_stall;
		adv_s1    = valid_s1 && s2_free;
		in_m.lb   = metric_lbearing;
		in_m.rb   = metric_rbearing;
		in_m.w    = metric_width;
		in_m.asc  = metric_ascent;
		in_m.desc = metric_descent;
		ent_ext   = 17'(entry_index);
		// drop loads beyond the table
		ram_we    = in_acc && (in_op == OP_LOAD) && (ent_ext < 17'(TABLE_DEPTH));
	end

	gmte_index u_pri_index (
		.row      (char_row),
		.col      (char_col),
		.allow_1d (1'b1),
		.cfg      (cfg_q),
		.result   (pri_lk)
	);

	// default character always uses the two-byte rule
	gmte_index u_def_index (
		.row      (cfg_q.default_code[15:8]),
		.col      (cfg_q.default_code[7:0]),
		.allow_1d (1'b0),
		.cfg      (cfg_q),
		.result   (def_lk)
	);

	gmte_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (MW),
		.AW    (TBL_AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ent_ext[TBL_AW-1:0]),
		.wdata   (in_m),
		.re      (in_acc),
		.raddr_a (pri_lk.idx),
		.raddr_b (def_lk.idx),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Common metrics update at accept; an older character leaving stage one on
	// the same edge still sees the previous values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_q <= '0;
		end else if (in_acc && (in_op == OP_COMMON)) begin
			common_q <= in_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= in_op;
			pri_ok_s1 <= pri_lk.ok;
			def_ok_s1 <= def_lk.ok;
		end
	end

	// Stage one: an all-zero table entry counts as missing; common metrics never do.
	always_comb begin
		pri_m     = metrics_t'(rd_a);
		def_m     = metrics_t'(rd_b);
		pri_found = pri_ok_s1 && (!cfg_q.table_present || (pri_m != '0));
		def_found = def_ok_s1 && (!cfg_q.table_present || (def_m != '0));
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s2    <= op_s1;
			found_s2 <= pri_found || def_found;
			if (!cfg_q.table_present) begin
				m_s2 <= common_q;
			end else if (pri_found) begin
				m_s2 <= pri_m;
			end else begin
				m_s2 <= def_m;
			end
		end
	end

	always_comb begin
		item_s2.valid = valid_s2;
		item_s2.op    = op_s2;
		item_s2.found = found_s2;
		item_s2.m     = m_s2;
	end

	gmte_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_s2),
		.blocked        (blocked),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.total_width    (total_width),
		.total_ascent   (total_ascent),
		.total_descent  (total_descent),
		.total_lbearing (total_lbearing),
		.total_rbearing (total_rbearing),
		.chars_found    (chars_found)
	);

	// An empty string reports all-zero totals.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (chars_found == 16'd0)) |->
		((total_width == 32'sd0) && (total_ascent == 16'sd0) &&
		 (total_descent == 16'sd0) && (total_lbearing == 32'sd0) &&
		 (total_rbearing == 32'sd0)))
		else $error("nonzero totals with no characters found");

	// Input stall only comes from an occupied, blocked pipeline.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && blocked && (op_s2 == OP_END)))
		else $error("input stalled without a blocked end op");

	// A blocked end op stays in stage two.
	a_block_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && blocked) |=> (valid_s2 && (op_s2 == OP_END)))
		else $error("blocked end op lost from stage two");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for glyph_metrics_text_extents_top: text extents totals per string.
// Predicts each end transaction's totals from its own copy of the tables and accumulators.
// Depends on gmte_pkg and the block's RTL only.
`default_nettype none

module testbench;
	import gmte_pkg::*;

	// Allow this many cycles without any transaction before declaring a hang.
	localparam int STALL_LIMIT  = 2000;
	// Let loads and characters still in the three-stage pipe settle before a register write.
	localparam int PIPE_SETTLE  = 8;
	localparam int SAT_RUN      = 50;

	localparam cfg_t CFG_AT_RESET = '{min_col: 8'd0, max_col: 8'd255, min_row: 8'd0,
		max_row: 8'd0, default_code: 16'h0000, table_present: 1'b1};

	typedef struct packed {
		op_t        op;
		logic [7:0] row;
		logic [7:0] col;
		logic [11:0] entry;
		metrics_t   m;
	} glyph_item_t;

	typedef struct packed {
		logic [31:0] width;
		logic [15:0] asc;
		logic [15:0] desc;
		logic [31:0] lb;
		logic [31:0] rb;
		logic [15:0] count;
	} extents_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index = REG_MIN_COL;
	logic [15:0]       cfg_data  = 16'h0000;

	logic              in_valid  = 1'b0;
	logic              in_stall;
	glyph_item_t       drv       = '0;

	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [31:0] total_width;
	logic signed [15:0] total_ascent;
	logic signed [15:0] total_descent;
	logic signed [31:0] total_lbearing;
	logic signed [31:0] total_rbearing;
	logic [15:0]       chars_found;

	// Stimulus side: items waiting to be sent, and the generator's view of the block.
	glyph_item_t char_stream[$];
	glyph_item_t launch;
	cfg_t        gen_cfg;
	bit          loaded[TABLE_DEPTH];
	int          items_made;

	// Prediction side: shadow of the registers, tables and accumulators.
	cfg_t        live_cfg;
	metrics_t    glyph_tbl[TABLE_DEPTH];
	metrics_t    common_m;
	int          acc_w, acc_asc, acc_desc, acc_l, acc_r, found_cnt;
	extents_t    totals_due[$];

	int          err_count;
	int          idle_cycles;
	int          burst_left, gap_left;
	int          stall_mode, mode_left;

	glyph_metrics_text_extents_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (drv.op),
		.char_row       (drv.row),
		.char_col       (drv.col),
		.entry_index    (drv.entry),
		.metric_lbearing(drv.m.lb),
		.metric_rbearing(drv.m.rb),
		.metric_width   (drv.m.w),
		.metric_ascent  (drv.m.asc),
		.metric_descent (drv.m.desc),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.total_width    (total_width),
		.total_ascent   (total_ascent),
		.total_descent  (total_descent),
		.total_lbearing (total_lbearing),
		.total_rbearing (total_rbearing),
		.chars_found    (chars_found)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- lookup rules

	// Two-byte rule: in range when both bytes sit inside their windows; an inverted
	// window never matches. Index is row offset times row length plus column offset.
	function automatic bit code_index(cfg_t c, int row, int col, output int idx);
		idx = (row - int'(c.min_row)) * (int'(c.max_col) - int'(c.min_col) + 1)
			+ (col - int'(c.min_col));
		return row >= int'(c.min_row) && row <= int'(c.max_row)
			&& col >= int'(c.min_col) && col <= int'(c.max_col);
	endfunction

	// Single-row font: with max_row zero a zero row byte checks the column only.
	function automatic bit primary_index(cfg_t c, int row, int col, output int idx);
		if (c.max_row == 8'd0 && row == 0) begin
			idx = col - int'(c.min_col);
			return col >= int'(c.min_col) && col <= int'(c.max_col);
		end
		return code_index(c, row, col, idx);
	endfunction

	// Common metrics are never missing; a table entry of all zeros is, and so is
	// any index past the end of the table.
	function automatic bit read_metrics(int idx, output metrics_t m);
		m = '0;
		if (!live_cfg.table_present) begin
			m = common_m;
			return 1'b1;
		end
		if (idx < 0 || idx >= TABLE_DEPTH)
			return 1'b0;
		m = glyph_tbl[idx];
		return m != '0;
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return int'(v);
	endfunction

	// ---------------------------------------------------------------- predictor

	task automatic clear_totals();
		acc_w = 0;
		acc_asc = 0;
		acc_desc = 0;
		acc_l = 0;
		acc_r = 0;
		found_cnt = 0;
	endtask

	// Advance the shadow state by one accepted transaction.
	task automatic fold_item(glyph_item_t it);
		metrics_t m;
		int       idx;
		bit       hit;
		int       lb, rb, w, asc, desc;
		longint   l, r;
		extents_t t;
		case (it.op)
			OP_LOAD:   glyph_tbl[it.entry] = it.m;
			OP_COMMON: common_m = it.m;
			OP_CHAR: begin
				hit = primary_index(live_cfg, it.row, it.col, idx) && read_metrics(idx, m);
				// Fall back on the default character, always by the two-byte rule.
				if (!hit)
					hit = code_index(live_cfg, live_cfg.default_code[15:8],
						live_cfg.default_code[7:0], idx) && read_metrics(idx, m);
				if (hit) begin
					lb = $signed(m.lb);
					rb = $signed(m.rb);
					w = $signed(m.w);
					asc = $signed(m.asc);
					desc = $signed(m.desc);
					if (found_cnt == 0) begin
						acc_w = w;
						acc_asc = asc;
						acc_desc = desc;
						acc_l = lb;
						acc_r = rb;
					end else begin
						// Bearings are relative to the pen position before this glyph.
						l = longint'(acc_w) + lb;
						r = longint'(acc_w) + rb;
						if (asc > acc_asc)
							acc_asc = asc;
						if (desc > acc_desc)
							acc_desc = desc;
						if (l < longint'(acc_l))
							acc_l = clamp32(l);
						if (r > longint'(acc_r))
							acc_r = clamp32(r);
						acc_w = clamp32(longint'(acc_w) + w);
					end
					if (found_cnt < 65535)
						found_cnt++;
				end
			end
			OP_END: begin
				t = '0;
				if (found_cnt != 0)
					t = '{32'(acc_w), 16'(acc_asc), 16'(acc_desc), 32'(acc_l),
						32'(acc_r), 16'(found_cnt)};
				totals_due.push_back(t);
				clear_totals();
			end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// ---------------------------------------------------------------- monitor

	// Sample both channels and the register port at the edge, then feed the
	// shadow model and compare the totals; also run the hang watchdog.
	always @(posedge clk or negedge arst_n) begin
		extents_t want;
		if (!arst_n) begin
			live_cfg = CFG_AT_RESET;
			common_m = '0;
			clear_totals();
			idle_cycles = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_COL:       live_cfg.min_col = cfg_data[7:0];
					REG_MAX_COL:       live_cfg.max_col = cfg_data[7:0];
					REG_MIN_ROW:       live_cfg.min_row = cfg_data[7:0];
					REG_MAX_ROW:       live_cfg.max_row = cfg_data[7:0];
					REG_DEFAULT_CODE:  live_cfg.default_code = cfg_data;
					REG_TABLE_PRESENT: live_cfg.table_present = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				fold_item(drv);
			if (out_valid && !out_stall) begin
				if (totals_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result: width %h count %h",
							total_width, chars_found);
				end else begin
					want = totals_due.pop_front();
					check_field("total_width", want.width, total_width);
					check_field("total_ascent", {16'h0, want.asc}, {16'h0, total_ascent});
					check_field("total_descent", {16'h0, want.desc}, {16'h0, total_descent});
					check_field("total_lbearing", want.lb, total_lbearing);
					check_field("total_rbearing", want.rb, total_rbearing);
					check_field("chars_found", {16'h0, want.count}, {16'h0, chars_found});
				end
			end
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall)
				|| (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- driver

	// Send queued items in bursts of random length with random gaps; hold the
	// payload while the block stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (char_stream.size() != 0) begin
				launch = char_stream.pop_front();
				drv <= launch;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
						: $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: switch among no stall, light, heavy and long
	// square-wave stretches of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else if (mode_left == 0) begin
			out_stall <= 1'b0;
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(32, 400);
		end else begin
			mode_left <= mode_left - 1;
			case (stall_mode)
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				2:       out_stall <= ($urandom_range(0, 3) != 0);
				3:       out_stall <= mode_left[4];
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// ---------------------------------------------------------------- generator

	function automatic logic [15:0] rand_metric16();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic metrics_t rand_metrics();
		if ($urandom_range(0, 9) == 0)
			return '0;
		return '{rand_metric16(), rand_metric16(), rand_metric16(), rand_metric16(),
			rand_metric16()};
	endfunction

	function automatic metrics_t metrics_of(int lb, int rb, int w, int asc, int desc);
		return '{16'(lb), 16'(rb), 16'(w), 16'(asc), 16'(desc)};
	endfunction

	// Fill every field at random so unused bits still toggle.
	function automatic glyph_item_t random_item();
		glyph_item_t it;
		it.op = op_t'($urandom_range(0, 3));
		it.row = 8'($urandom);
		it.col = 8'($urandom);
		it.entry = 12'($urandom);
		it.m = '{rand_metric16(), rand_metric16(), rand_metric16(), rand_metric16(),
			rand_metric16()};
		return it;
	endfunction

	task automatic push_item(glyph_item_t it);
		if (it.op == OP_LOAD)
			loaded[it.entry] = 1'b1;
		char_stream.push_back(it);
		items_made++;
	endtask

	task automatic push_load(int idx, metrics_t m);
		glyph_item_t it;
		it = random_item();
		it.op = OP_LOAD;
		it.entry = 12'(idx);
		it.m = m;
		push_item(it);
	endtask

	task automatic push_common(metrics_t m);
		glyph_item_t it;
		it = random_item();
		it.op = OP_COMMON;
		it.m = m;
		push_item(it);
	endtask

	task automatic push_end();
		glyph_item_t it;
		it = random_item();
		it.op = OP_END;
		push_item(it);
	endtask

	function automatic bool_unloaded(int idx);
		return gen_cfg.table_present && idx >= 0 && idx < TABLE_DEPTH && !loaded[idx];
	endfunction

	// Never let a character read a table entry that was never loaded: load it first.
	task automatic push_char(int row, int col);
		glyph_item_t it;
		int          idx;
		if (primary_index(gen_cfg, row, col, idx) && bool_unloaded(idx))
			push_load(idx, rand_metrics());
		it = random_item();
		it.op = OP_CHAR;
		it.row = 8'(row);
		it.col = 8'(col);
		push_item(it);
	endtask

	task automatic preload_default();
		int idx;
		if (code_index(gen_cfg, gen_cfg.default_code[15:8], gen_cfg.default_code[7:0], idx)
			&& bool_unloaded(idx))
			push_load(idx, rand_metrics());
	endtask

	// Favor codes inside the window; keep rows near the bottom so that wide
	// fonts still land inside the table often.
	function automatic int pick_row();
		int lo = gen_cfg.min_row;
		int hi = gen_cfg.max_row;
		if (hi == 0 && $urandom_range(0, 2) != 0)
			return 0;
		if (lo <= hi && $urandom_range(0, 3) != 0)
			return $urandom_range(lo, (hi < lo + 24) ? hi : lo + 24);
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_col();
		int lo = gen_cfg.min_col;
		int hi = gen_cfg.max_col;
		if (lo <= hi && $urandom_range(0, 3) != 0)
			return $urandom_range(lo, hi);
		return $urandom_range(0, 255);
	endfunction

	// Mostly well-formed strings (characters, a few reloads, then an end);
	// the rest is single random transactions.
	task automatic push_random(int n);
		glyph_item_t it;
		int          stop, len, idx;
		stop = items_made + n;
		while (items_made < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				it = random_item();
				if (it.op == OP_CHAR)
					push_char(it.row, it.col);
				else
					push_item(it);
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
					: $urandom_range(0, 10);
				repeat (len) begin
					case ($urandom_range(0, 11))
						0: begin
							if (primary_index(gen_cfg, pick_row(), pick_col(), idx)
								&& idx >= 0 && idx < TABLE_DEPTH)
								push_load(idx, rand_metrics());
							else
								push_load($urandom_range(0, TABLE_DEPTH - 1), rand_metrics());
						end
						1:       push_common(rand_metrics());
						default: push_char(pick_row(), pick_col());
					endcase
				end
				push_end();
			end
		end
	endtask

	task automatic write_reg(cfg_reg_t r, logic [15:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int mc, int xc, int mr, int xr, int dc, int tp);
		gen_cfg = '{min_col: 8'(mc), max_col: 8'(xc), min_row: 8'(mr), max_row: 8'(xr),
			default_code: 16'(dc), table_present: 1'(tp)};
		write_reg(REG_MIN_COL, 16'(gen_cfg.min_col));
		write_reg(REG_MAX_COL, 16'(gen_cfg.max_col));
		write_reg(REG_MIN_ROW, 16'(gen_cfg.min_row));
		write_reg(REG_MAX_ROW, 16'(gen_cfg.max_row));
		write_reg(REG_DEFAULT_CODE, gen_cfg.default_code);
		write_reg(REG_TABLE_PRESENT, 16'(gen_cfg.table_present));
		preload_default();
	endtask

	// Wait until everything is sent and every expected total has come back,
	// then give the pipe time to retire loads and characters that make no result.
	task automatic drain();
		while (char_stream.size() != 0 || in_valid || totals_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- test sequence

	initial begin
		err_count = 0;
		items_made = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: single-row font over all columns, default code 0.
		gen_cfg = CFG_AT_RESET;
		preload_default();
		// Empty string returns all zeros.
		push_end();
		push_load(0, metrics_of(-32768, 32767, 32767, -32768, 32767));
		push_load(4095, metrics_of(32767, -32768, -32768, 32767, -32768));
		push_load(255, metrics_of(-3, 9, 12, 20, 4));
		// All-zero entry marks a nonexistent character.
		push_load(65, '0);
		push_load(66, metrics_of(1, -1, -32768, 7, -2));
		push_common(metrics_of(32767, -32768, 32767, -32768, 32767));
		// First character seeds the totals; then a hit, a missing entry, a row
		// outside a single-row font and the far corner; all but the hit fall back on the default.
		push_char(0, 255);
		push_char(0, 66);
		push_char(0, 65);
		push_char(1, 0);
		push_char(255, 255);
		push_end();
		// Default entry missing too: the character is skipped.
		push_load(0, '0);
		push_char(0, 65);
		push_end();
		push_char(0, 255);
		push_end();
		push_char(0, 0);
		push_end();
		push_random(200);
		drain();

		// Multi-row font with a narrow column window.
		set_config(32, 126, 1, 40, 16'h0120, 1);
		push_random(250);
		drain();

		// Full code space: most rows index past the table; default out of table.
		set_config(0, 255, 0, 255, 16'hffff, 1);
		push_random(250);
		drain();

		// Common metrics; then long runs of one character at extreme metrics,
		// growing width and bearings both ways.
		set_config(10, 200, 0, 5, 16'h0005, 0);
		push_random(200);
		push_common(metrics_of(0, 32767, 32767, 5, 3));
		repeat (SAT_RUN) push_char(0, 20);
		push_end();
		push_common(metrics_of(-32768, -32768, -32768, -7, -9));
		repeat (SAT_RUN) push_char(0, 20);
		push_end();
		drain();

		// Inverted column window: nothing is ever found.
		set_config(200, 0, 0, 0, 16'h0000, 1);
		push_random(150);
		drain();

		// One-cell font at the top corner.
		set_config(255, 255, 255, 255, 16'hffff, 1);
		push_random(150);
		drain();

		// Inverted row window with common metrics: nothing is found either.
		set_config(0, 255, 9, 3, 16'h0905, 0);
		push_random(100);
		drain();

		// Single-row font with an offset column window.
		set_config(64, 191, 0, 0, 16'h0040, 1);
		push_random(200);
		drain();

		if (err_count == 0 && totals_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
